### sv/suset_pkg.sv
// Package: shared codes and types of the sorted unique set table.
`default_nettype none

package suset_pkg;

    // Request kinds
    localparam logic [2:0] KIND_INSERT = 3'd0;
    localparam logic [2:0] KIND_REMOVE = 3'd1;
    localparam logic [2:0] KIND_SEARCH = 3'd2;
    localparam logic [2:0] KIND_FIRST  = 3'd3;
    localparam logic [2:0] KIND_NEXT   = 3'd4;
    localparam logic [2:0] KIND_CLEAR  = 3'd5;

    // Result status codes
    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_DUP    = 3'd1;
    localparam logic [2:0] ST_ABSENT = 3'd2;
    localparam logic [2:0] ST_FULL   = 3'd3;
    localparam logic [2:0] ST_END    = 3'd4;

    // Update commands broadcast to every cell
    typedef struct packed {
        logic ins;
        logic rem;
    } t_cell_ctl;

    // Compare flags returned by every cell
    typedef struct packed {
        logic lt;
        logic eq;
    } t_cell_flag;

endpackage

`default_nettype wire

### sv/suset_cell.sv
// Table cell: holds one sorted entry, compares it and shifts with its neighbours.
`default_nettype none

module suset_cell #(
    parameter int IDX = 0,
    parameter int CW  = 7
) (
    input  wire                        i_clk,
    input  wire  [CW-1:0]              i_count,
    input  suset_pkg::t_cell_ctl       i_ctl,
    input  wire  signed [31:0]         i_value,
    input  wire                        i_left_lt,
    input  wire  signed [31:0]         i_left_val,
    input  wire  signed [31:0]         i_right_val,
    output logic signed [31:0]         o_val,
    output suset_pkg::t_cell_flag      o_flag
);

    logic signed [31:0] r_val;
    logic signed [31:0] n_val;
    logic               w_occupied;

    assign w_occupied  = CW'(IDX) < i_count;
    assign o_flag.lt   = w_occupied && (r_val < i_value);
    assign o_flag.eq   = w_occupied && (r_val == i_value);
    assign o_val       = r_val;

    always_comb begin
        n_val = r_val;
        if (i_ctl.ins && !o_flag.lt) begin
            // first cell not below the operand takes it, the rest move up
            n_val = i_left_lt ? i_value : i_left_val;
        end else if (i_ctl.rem && !o_flag.lt) begin
            n_val = i_right_val;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

endmodule

`default_nettype wire

### sv/sorted_unique_set_table_unit.sv
// Top level: sorted unique set table built as a row of compare-and-shift cells.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+----------------------------
//   request | in        | i_in_valid / o_in_stall | i_kind, i_value
//   result  | out       | o_out_valid / i_out_stall | o_status, o_item, o_count
//
// A request executes once it is registered and the result register is free: all
// cells compare in parallel and shift in that same cycle, and the result is registered.
// One request per cycle is sustained while results are taken; a result held
// by i_out_stall holds the executing request, and with it the input side.
// Reset empties the table and invalidates the walk cursor; cell contents
// stay undefined, as cells at or beyond the count are never read.
`default_nettype none

module sorted_unique_set_table_unit #(
    parameter int CAPACITY = 64
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    output logic               o_in_stall,
    input  wire  [2:0]         i_kind,
    input  wire  signed [31:0] i_value,
    output logic               o_out_valid,
    input  wire                i_out_stall,
    output logic [2:0]         o_status,
    output logic signed [31:0] o_item,
    output logic [6:0]         o_count
);

    localparam int CW = $clog2(CAPACITY + 1);

    logic               r_busy;
    logic [2:0]         r_kind;
    logic signed [31:0] r_value;
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      r_cur;
    logic               r_cur_valid;
    logic               r_out_valid;
    logic [2:0]         r_status;
    logic signed [31:0] r_item;

    logic [CW-1:0]      n_count;
    logic [CW-1:0]      n_cur;
    logic               n_cur_valid;
    logic [2:0]         n_status;
    logic signed [31:0] n_item;

    logic                  w_in_accept;
    logic                  w_exec_go;
    logic                  w_found;
    logic                  w_full;
    logic signed [31:0]    w_cur_item;
    suset_pkg::t_cell_ctl  w_ctl;
    suset_pkg::t_cell_ctl  w_ctl_go;

    logic signed [31:0]    w_val  [CAPACITY];
    suset_pkg::t_cell_flag w_flag [CAPACITY];

    // execute only once the result register is free
    assign w_exec_go   = r_busy && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_busy && !w_exec_go;
    assign w_in_accept = i_in_valid && !o_in_stall;
    assign w_full      = r_count == CW'(CAPACITY);

    assign w_ctl_go.ins = w_ctl.ins && w_exec_go;
    assign w_ctl_go.rem = w_ctl.rem && w_exec_go;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic               w_left_lt;
        logic signed [31:0] w_left_val;
        logic signed [31:0] w_right_val;

        if (g == 0) begin : g_head
            assign w_left_lt  = 1'b1;
            assign w_left_val = r_value;
        end else begin : g_body
            assign w_left_lt  = w_flag[g-1].lt;
            assign w_left_val = w_val[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign w_right_val = w_val[g];
        end else begin : g_inner
            assign w_right_val = w_val[g+1];
        end

        suset_cell #(
            .IDX (g),
            .CW  (CW)
        ) u_cell (
            .i_clk       (i_clk),
            .i_count     (r_count),
            .i_ctl       (w_ctl_go),
            .i_value     (r_value),
            .i_left_lt   (w_left_lt),
            .i_left_val  (w_left_val),
            .i_right_val (w_right_val),
            .o_val       (w_val[g]),
            .o_flag      (w_flag[g])
        );
    end

    always_comb begin
        w_found    = 1'b0;
        w_cur_item = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            w_found = w_found | w_flag[i].eq;
            if (r_cur == CW'(i)) begin
                w_cur_item = w_cur_item | w_val[i];
            end
        end
    end

    always_comb begin
        n_status    = suset_pkg::ST_OK;
        n_item      = '0;
        n_count     = r_count;
        n_cur       = r_cur;
        n_cur_valid = r_cur_valid;
        w_ctl       = '0;
        case (r_kind)
            suset_pkg::KIND_INSERT: begin
                if (w_found) begin
                    n_status = suset_pkg::ST_DUP;
                end else if (w_full) begin
                    n_status = suset_pkg::ST_FULL;
                end else begin
                    w_ctl.ins   = 1'b1;
                    n_count     = r_count + CW'(1);
                    n_cur_valid = 1'b0;
                end
            end
            suset_pkg::KIND_REMOVE: begin
                if (!w_found) begin
                    n_status = suset_pkg::ST_ABSENT;
                end else begin
                    w_ctl.rem   = 1'b1;
                    n_count     = r_count - CW'(1);
                    n_cur_valid = 1'b0;
                end
            end
            suset_pkg::KIND_SEARCH: begin
                n_status = w_found ? suset_pkg::ST_OK : suset_pkg::ST_ABSENT;
            end
            suset_pkg::KIND_FIRST: begin
                if (r_count == '0) begin
                    n_status    = suset_pkg::ST_END;
                    n_cur_valid = 1'b0;
                end else begin
                    n_item      = w_val[0];
                    n_cur       = CW'(1);
                    n_cur_valid = 1'b1;
                end
            end
            suset_pkg::KIND_NEXT: begin
                if (r_cur_valid && (r_cur < r_count)) begin
                    n_item = w_cur_item;
                    n_cur  = r_cur + CW'(1);
                end else begin
                    n_status    = suset_pkg::ST_END;
                    n_cur_valid = 1'b0;
                end
            end
            suset_pkg::KIND_CLEAR: begin
                n_count     = '0;
                n_cur_valid = 1'b0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_count     <= '0;
            r_cur       <= '0;
            r_cur_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_accept) begin
                r_busy <= 1'b1;
            end else if (w_exec_go) begin
                r_busy <= 1'b0;
            end
            if (w_exec_go) begin
                r_count     <= n_count;
                r_cur       <= n_cur;
                r_cur_valid <= n_cur_valid;
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload: hold the request and the result, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_kind  <= i_kind;
            r_value <= i_value;
        end
        if (w_exec_go) begin
            r_status <= n_status;
            r_item   <= n_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_item      = r_item;
    assign o_count     = 7'(r_count);

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("held count exceeds capacity");

    a_cursor_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur_valid |-> (r_cur <= r_count))
        else $error("walk cursor beyond held count");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl_go.ins |=> (r_count == $past(r_count) + CW'(1)))
        else $error("insert did not grow the count");

    a_remove_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl_go.rem |=> (r_count == $past(r_count) - CW'(1)))
        else $error("remove did not shrink the count");

    a_single_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_ctl_go.ins && w_ctl_go.rem))
        else $error("insert and remove issued together");
`endif

endmodule

`default_nettype wire

### tb/sv/tb_sorted_unique_set_table_unit.sv
// Testbench for the sorted unique set table unit: random and directed requests, scoreboard.
`default_nettype none

typedef struct {
    logic [2:0]         status;
    logic signed [31:0] item;
    logic [6:0]         count;
} t_table_result;

class set_table_scoreboard;
    int            capacity;
    int            held[$];
    int            cursor_pos;
    bit            cursor_live;
    t_table_result expected_results[$];
    int            mismatches;
    int            results_checked;
    int            requests_noted;
    int            fullest;
    int            status_seen[5];

    function new(int cap);
        capacity    = cap;
        cursor_pos  = 0;
        cursor_live = 1'b0;
        mismatches  = 0;
        fullest     = 0;
        results_checked = 0;
        requests_noted  = 0;
        foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function int pending();
        return expected_results.size();
    endfunction

    function bit has_values();
        return held.size() > 0;
    endfunction

    function int any_held();
        return held[$urandom_range(0, held.size() - 1)];
    endfunction

    task report_mismatch(string what);
        // keep the log short but count every miss
        if (mismatches < 100) $display("MISMATCH at %0t: %s", $time, what);
        mismatches++;
    endtask

    // Update the table copy for one accepted request and queue its result
    function void note_request(logic [2:0] kind, logic signed [31:0] value);
        t_table_result r;
        int            rank;
        bit            present;
        r.status = suset_pkg::ST_OK;
        r.item   = '0;
        rank     = 0;
        foreach (held[i]) if (held[i] < value) rank++;
        present = (rank < held.size()) && (held[rank] == value);
        case (kind)
            suset_pkg::KIND_INSERT: begin
                if (present) begin
                    r.status = suset_pkg::ST_DUP;
                end else if (held.size() >= capacity) begin
                    r.status = suset_pkg::ST_FULL;
                end else begin
                    held.insert(rank, value);
                    cursor_live = 1'b0;
                end
            end
            suset_pkg::KIND_REMOVE: begin
                if (!present) begin
                    r.status = suset_pkg::ST_ABSENT;
                end else begin
                    held.delete(rank);
                    cursor_live = 1'b0;
                end
            end
            suset_pkg::KIND_SEARCH: begin
                r.status = present ? suset_pkg::ST_OK : suset_pkg::ST_ABSENT;
            end
            suset_pkg::KIND_FIRST: begin
                if (held.size() == 0) begin
                    r.status    = suset_pkg::ST_END;
                    cursor_live = 1'b0;
                end else begin
                    r.item      = held[0];
                    cursor_pos  = 1;
                    cursor_live = 1'b1;
                end
            end
            suset_pkg::KIND_NEXT: begin
                if (cursor_live && cursor_pos < held.size()) begin
                    r.item = held[cursor_pos];
                    cursor_pos++;
                end else begin
                    r.status    = suset_pkg::ST_END;
                    cursor_live = 1'b0;
                end
            end
            suset_pkg::KIND_CLEAR: begin
                held.delete();
                cursor_live = 1'b0;
            end
            default: ;
        endcase
        r.count = 7'(held.size());
        if (held.size() > fullest) fullest = held.size();
        requests_noted++;
        expected_results.push_back(r);
    endfunction

    task check_result(logic [2:0] status, logic signed [31:0] item, logic [6:0] count);
        t_table_result want;
        if (expected_results.size() == 0) begin
            report_mismatch("result arrived with no request outstanding");
        end else begin
            want = expected_results.pop_front();
            if (status !== want.status)
                report_mismatch($sformatf("status %0d, expected %0d", status, want.status));
            if (item !== want.item)
                report_mismatch($sformatf("item %0d, expected %0d", item, want.item));
            if (count !== want.count)
                report_mismatch($sformatf("count %0d, expected %0d", count, want.count));
            if (want.status <= suset_pkg::ST_END) status_seen[want.status]++;
            results_checked++;
        end
    endtask
endclass

module tb_sorted_unique_set_table_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAPACITY     = 64;
    localparam int RANDOM_ITEMS = 1325;
    localparam int QUIET_TAIL   = 150;
    localparam int LONG_HOLD    = 40;
    localparam int CYCLE_LIMIT  = 200000;

    // kinds the block treats as no operation
    localparam logic [2:0] KIND_SPARE_LO = 3'd6;
    localparam logic [2:0] KIND_SPARE_HI = 3'd7;

    typedef enum int {LOAD_FILL, LOAD_DRAIN, LOAD_WALK, LOAD_ANY} t_workload;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    logic [2:0]         i_kind;
    logic signed [31:0] i_value;
    logic               o_out_valid;
    logic               i_out_stall;
    logic [2:0]         o_status;
    logic signed [31:0] o_item;
    logic [6:0]         o_count;

    set_table_scoreboard sb;
    bit                  idle_enable;
    bit                  long_hold_pending;
    int                  cycle_count;

    sorted_unique_set_table_unit #(.CAPACITY(CAPACITY)) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_kind      (i_kind),
        .i_value     (i_value),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_status    (o_status),
        .o_item      (o_item),
        .o_count     (o_count)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result(o_status, o_item, o_count);
    end

    // Result side: short random stalls, plus one long hold-off on demand
    initial begin : result_side
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (long_hold_pending) begin
                stall_left        = LONG_HOLD;
                long_hold_pending = 1'b0;
            end
            if (stall_left > 0) begin
                i_out_stall <= 1'b1;
                stall_left--;
            end else if (idle_enable && $urandom_range(0, 4) == 0) begin
                i_out_stall <= 1'b1;
                stall_left = $urandom_range(0, 2);
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // Offer one request, hold it until accepted, then note it
    task automatic send_request(input logic [2:0] kind, input logic signed [31:0] value);
        if (idle_enable && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_kind     <= kind;
        i_value    <= value;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_request(kind, value);
        @(negedge i_clk);
    endtask

    function automatic logic [2:0] pick_kind(t_workload mode);
        int r;
        r = $urandom_range(0, 99);
        case (mode)
            LOAD_FILL: begin
                return r < 75 ? suset_pkg::KIND_INSERT : r < 85 ? suset_pkg::KIND_SEARCH :
                       r < 92 ? suset_pkg::KIND_REMOVE : r < 96 ? suset_pkg::KIND_FIRST :
                       suset_pkg::KIND_NEXT;
            end
            LOAD_DRAIN: begin
                return r < 60 ? suset_pkg::KIND_REMOVE : r < 75 ? suset_pkg::KIND_INSERT :
                       r < 88 ? suset_pkg::KIND_SEARCH : r < 94 ? suset_pkg::KIND_FIRST :
                       suset_pkg::KIND_NEXT;
            end
            LOAD_WALK: begin
                return r < 15 ? suset_pkg::KIND_FIRST : r < 75 ? suset_pkg::KIND_NEXT :
                       r < 85 ? suset_pkg::KIND_INSERT : r < 92 ? suset_pkg::KIND_SEARCH :
                       suset_pkg::KIND_REMOVE;
            end
            default: begin
                if (r < 1) return KIND_SPARE_LO;
                if (r < 2) return KIND_SPARE_HI;
                if (r < 8) return suset_pkg::KIND_CLEAR;
                return 3'($urandom_range(0, 4));
            end
        endcase
    endfunction

    function automatic logic signed [31:0] pick_value(logic [2:0] kind);
        int r;
        r = $urandom_range(0, 9);
        if (kind == suset_pkg::KIND_REMOVE || kind == suset_pkg::KIND_SEARCH) begin
            if (r < 6 && sb.has_values()) return sb.any_held();
        end else if (kind == suset_pkg::KIND_INSERT) begin
            if (r < 1 && sb.has_values()) return sb.any_held();
        end
        case ($urandom_range(0, 9))
            0, 1:    return $signed(32'($urandom_range(0, 80))) - 40;
            2: begin
                case ($urandom_range(0, 3))
                    0:       return 32'sh8000_0000;
                    1:       return 32'sh7fff_ffff;
                    2:       return -32'sd1;
                    default: return 32'sd0;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    initial begin : stimulus
        t_workload  mode;
        int         sent;
        int         phase;
        int         span;
        logic [2:0] kind;

        sb                = new(CAPACITY);
        i_rst_n           = 1'b0;
        i_in_valid        = 1'b0;
        i_kind            = suset_pkg::KIND_INSERT;
        i_value           = '0;
        i_out_stall       = 1'b0;
        idle_enable       = 1'b0;
        long_hold_pending = 1'b0;
        cycle_count       = 0;

        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: empty table, extremes, walk to the end and past it,
        // cursor dropped by changes, unused kinds, clear
        send_request(suset_pkg::KIND_FIRST,  32'sd0);
        send_request(suset_pkg::KIND_NEXT,   32'sd0);
        send_request(suset_pkg::KIND_REMOVE, 32'sd0);
        send_request(suset_pkg::KIND_SEARCH, 32'sd0);
        send_request(suset_pkg::KIND_INSERT, 32'sh7fff_ffff);
        send_request(suset_pkg::KIND_INSERT, 32'sh8000_0000);
        send_request(suset_pkg::KIND_INSERT, 32'sd0);
        send_request(suset_pkg::KIND_INSERT, 32'sd0);
        send_request(suset_pkg::KIND_SEARCH, 32'sh8000_0000);
        send_request(suset_pkg::KIND_SEARCH, -32'sd1);
        send_request(suset_pkg::KIND_FIRST,  32'sd0);
        send_request(suset_pkg::KIND_NEXT,   32'sd0);
        send_request(suset_pkg::KIND_NEXT,   32'sd0);
        send_request(suset_pkg::KIND_NEXT,   32'sd0);
        send_request(suset_pkg::KIND_NEXT,   32'sd0);
        send_request(suset_pkg::KIND_FIRST,  32'sd0);
        send_request(suset_pkg::KIND_INSERT, 32'sd5);
        send_request(suset_pkg::KIND_NEXT,   32'sd0);
        send_request(suset_pkg::KIND_FIRST,  32'sd0);
        send_request(suset_pkg::KIND_REMOVE, 32'sd0);
        send_request(suset_pkg::KIND_NEXT,   32'sd0);
        send_request(KIND_SPARE_LO,          -32'sd1);
        send_request(KIND_SPARE_HI,          32'sh5555_aaaa);
        send_request(suset_pkg::KIND_CLEAR,  32'sh7fff_ffff);
        send_request(suset_pkg::KIND_FIRST,  32'sd0);

        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            // open with a long fill so the table reaches capacity early
            mode = (phase == 0) ? LOAD_FILL : t_workload'($urandom_range(0, 3));
            span = (phase == 0) ? 120 : $urandom_range(40, 120);
            idle_enable = ($urandom_range(0, 3) != 0);
            if (phase == 3) long_hold_pending = 1'b1;
            for (int n = 0; n < span && sent < RANDOM_ITEMS; n++) begin
                if (sent >= RANDOM_ITEMS - QUIET_TAIL) idle_enable = 1'b0;
                kind = pick_kind(mode);
                send_request(kind, pick_value(kind));
                sent++;
            end
            phase++;
        end
        i_in_valid <= 1'b0;

        while (sb.pending() > 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);

        $display("Checked %0d results from %0d requests over %0d phases;",
                 sb.results_checked, sb.requests_noted, phase);
        $display("fullest table %0d of %0d; ok %0d, duplicate %0d, absent %0d, full %0d, end %0d.",
                 sb.fullest, CAPACITY,
                 sb.status_seen[suset_pkg::ST_OK], sb.status_seen[suset_pkg::ST_DUP],
                 sb.status_seen[suset_pkg::ST_ABSENT], sb.status_seen[suset_pkg::ST_FULL],
                 sb.status_seen[suset_pkg::ST_END]);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule

`default_nettype wire
